// ===== hw/rtl/stride_dimension_collapser_defines.svh =====
// Assertion macros shared by the stride dimension collapser RTL.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef STRIDE_DIMENSION_COLLAPSER_DEFINES_SVH
`define STRIDE_DIMENSION_COLLAPSER_DEFINES_SVH
`ifndef SYNTHESIS
`define SDC_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDC_ASSERT(label, clk, rst_n, cond, msg)
`define SDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sdc_pkg.sv =====
// Types and constants of the stride dimension collapser.
// No dependencies; used by the lane front, core, output queue and top level.
package sdc_pkg;

    localparam int LANES    = 4;   // stride lanes on the ports
    localparam int EXT_W    = 31;
    localparam int STRIDE_W = 64;
    localparam int HALF_W   = 32;  // stride half fed to one lane multiplier
    localparam int PLO_W    = HALF_W + EXT_W;
    localparam int CAP_W    = 63;
    localparam int RS_W     = 63;  // running product, within size cap after a join
    localparam int CNT_W    = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CAP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_CAP      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_COUNT = 1'b1;

    localparam logic [CAP_W-1:0] SIZE_CAP_RESET      = 63'd2147483647;
    localparam logic [CNT_W-1:0] OPERAND_COUNT_RESET = 3'd1;

    localparam int MAX_EMIT   = 3;  // words one dimension can produce
    localparam int EMIT_CNT_W = 2;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    typedef logic [STRIDE_W-1:0] t_stride;
    typedef t_stride [LANES-1:0] t_strides;

    typedef struct packed {
        logic [EXT_W-1:0] ext;
        t_strides         strides;
        logic             fin;
    } t_item;

    typedef struct packed {
        t_item            item;
        logic [LANES-1:0] match;   // stride * extent equals previous stride
    } t_match_item;

    typedef struct packed {
        logic [EXT_W-1:0] ext;
        t_strides         strides;
        logic             fin;
    } t_word;

    typedef struct packed {
        logic [EMIT_CNT_W-1:0]     count;
        t_word [MAX_EMIT-1:0]      words;
    } t_emit;

endpackage

// ===== hw/rtl/sdc_in_if.sv =====
// Input channel of the stride dimension collapser: one dimension per word.
// Depends on nothing; field widths follow the dimension descriptor.
interface sdc_in_if;
    logic                valid;
    logic                ready;
    logic [30:0]         extent;
    logic signed [63:0]  stride_a;
    logic signed [63:0]  stride_b;
    logic signed [63:0]  stride_c;
    logic signed [63:0]  stride_d;
    logic                final_dim;

    modport source (
        output valid, extent, stride_a, stride_b, stride_c, stride_d, final_dim,
        input  ready
    );
    modport sink (
        input  valid, extent, stride_a, stride_b, stride_c, stride_d, final_dim,
        output ready
    );
endinterface

// ===== hw/rtl/sdc_out_if.sv =====
// Output channel of the stride dimension collapser: one merged dimension per word.
// Depends on nothing; field widths follow the merged descriptor.
interface sdc_out_if;
    logic                valid;
    logic                ready;
    logic [30:0]         merged_extent;
    logic signed [63:0]  merged_stride_a;
    logic signed [63:0]  merged_stride_b;
    logic signed [63:0]  merged_stride_c;
    logic signed [63:0]  merged_stride_d;
    logic                final_merged;

    modport source (
        output valid, merged_extent, merged_stride_a, merged_stride_b,
               merged_stride_c, merged_stride_d, final_merged,
        input  ready
    );
    modport sink (
        input  valid, merged_extent, merged_stride_a, merged_stride_b,
               merged_stride_c, merged_stride_d, final_merged,
        output ready
    );
endinterface

// ===== hw/rtl/sdc_lane_front.sv =====
// Per-lane contiguity front end: two stages that form stride * extent
// (mod 2^64) and compare it with the previous dimension's stride. Uses sdc_pkg.
module sdc_lane_front #(
    parameter int MAX_OPERANDS = 4
) (
    input  logic                i_clk,
    input  logic                i_ld1,
    input  logic                i_ld2,
    input  sdc_pkg::t_item      i_item,
    output sdc_pkg::t_match_item o_item
);

    typedef struct packed {
        sdc_pkg::t_item                                  item;
        sdc_pkg::t_strides                               prev;
        logic [sdc_pkg::LANES-1:0][sdc_pkg::PLO_W-1:0]   plo;
        logic [sdc_pkg::LANES-1:0][sdc_pkg::HALF_W-1:0]  phi;
    } t_s2;

    sdc_pkg::t_item    r_s1;
    sdc_pkg::t_strides r_s1_prev;
    t_s2               r_s2;
    t_s2               n_s2;
    logic [sdc_pkg::LANES-1:0][sdc_pkg::STRIDE_W-1:0] prod;
    logic [sdc_pkg::LANES-1:0]                        match;

    // r_s1 only changes on a new word, so it always holds the last one taken
    always_ff @(posedge i_clk) begin
        if (i_ld1) begin
            r_s1      <= i_item;
            r_s1_prev <= r_s1.strides;
        end
        if (i_ld2) begin
            r_s2 <= n_s2;
        end
    end

    // stage 1: low and high stride halves times extent, one 32x31 each
    always_comb begin
        n_s2.item = r_s1;
        n_s2.prev = r_s1_prev;
        for (int j = 0; j < sdc_pkg::LANES; j++) begin
            if (j < MAX_OPERANDS) begin
                n_s2.plo[j] = sdc_pkg::PLO_W'(r_s1.strides[j][sdc_pkg::HALF_W-1:0])
                            * sdc_pkg::PLO_W'(r_s1.ext);
                n_s2.phi[j] = r_s1.strides[j][sdc_pkg::STRIDE_W-1:sdc_pkg::HALF_W]
                            * sdc_pkg::HALF_W'(r_s1.ext);
            end else begin
                n_s2.plo[j] = '0;
                n_s2.phi[j] = '0;
            end
        end
    end

    // stage 2: recombine the halves and compare
    always_comb begin
        for (int j = 0; j < sdc_pkg::LANES; j++) begin
            prod[j]  = sdc_pkg::STRIDE_W'(r_s2.plo[j])
                     + {r_s2.phi[j], {sdc_pkg::HALF_W{1'b0}}};
            match[j] = (j >= MAX_OPERANDS) || (prod[j] == r_s2.prev[j]);
        end
    end

    assign o_item.item  = r_s2.item;
    assign o_item.match = match;

endmodule

// ===== hw/rtl/sdc_collapse_core.sv =====
// Grouping state of the collapser: running product, open group, held group.
// Uses sdc_pkg and the assertion macros; fed by sdc_lane_front.
`include "stride_dimension_collapser_defines.svh"
module sdc_collapse_core #(
    parameter int MAX_OPERANDS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ld3,
    input  logic                          i_go,
    input  sdc_pkg::t_match_item          i_item,
    input  logic [sdc_pkg::CAP_W-1:0]     i_size_cap,
    input  logic [sdc_pkg::CNT_W-1:0]     i_operand_count,
    output sdc_pkg::t_emit                o_emit
);

    localparam int PROD_W = sdc_pkg::RS_W + sdc_pkg::EXT_W;
    localparam int PHI_W  = sdc_pkg::RS_W - sdc_pkg::HALF_W + sdc_pkg::EXT_W;

    sdc_pkg::t_match_item r_s3;

    // control state
    logic r_first;
    logic r_gopen;
    logic r_hv;
    // payload state
    logic [sdc_pkg::RS_W-1:0]  r_rs;
    logic [sdc_pkg::EXT_W-1:0] r_gext;
    sdc_pkg::t_strides         r_gst;
    logic [sdc_pkg::EXT_W-1:0] r_hext;
    sdc_pkg::t_strides         r_hst;

    logic [sdc_pkg::CNT_W-1:0]  active;
    logic [sdc_pkg::LANES-1:0]  lane_on;
    logic                       lane_ok;
    logic [sdc_pkg::PLO_W-1:0]  rs_plo;
    logic [PHI_W-1:0]           rs_phi;
    logic [PROD_W-1:0]          rs_prod;
    logic                       le_cap;
    logic                       contig;
    logic                       joins;
    logic                       brk;
    logic [sdc_pkg::EXT_W-1:0]  gext_prod;

    logic                       h1v;
    logic [sdc_pkg::EXT_W-1:0]  h1ext;
    sdc_pkg::t_strides          h1st;
    logic                       g1open;
    logic                       g2open;
    logic [sdc_pkg::EXT_W-1:0]  g2ext;
    sdc_pkg::t_strides          g2st;
    logic                       h2v;
    logic [sdc_pkg::EXT_W-1:0]  h2ext;
    sdc_pkg::t_strides          h2st;
    logic [sdc_pkg::RS_W-1:0]   n_rs;
    logic [sdc_pkg::EMIT_CNT_W-1:0] cnt;
    sdc_pkg::t_word [sdc_pkg::MAX_EMIT-1:0] words;

    function automatic sdc_pkg::t_word mk(
        input logic [sdc_pkg::EXT_W-1:0] ext,
        input sdc_pkg::t_strides         st,
        input logic                      fin,
        input logic [sdc_pkg::LANES-1:0] on
    );
        sdc_pkg::t_word w;
        w.ext = ext;
        w.fin = fin;
        for (int j = 0; j < sdc_pkg::LANES; j++) begin
            w.strides[j] = on[j] ? st[j] : '0;
        end
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ld3) begin
            r_s3 <= i_item;
        end
    end

    // lanes in force: zero acts as one, clamp at MAX_OPERANDS
    always_comb begin
        if (i_operand_count == '0) begin
            active = sdc_pkg::CNT_W'(1);
        end else if (i_operand_count > sdc_pkg::CNT_W'(MAX_OPERANDS)) begin
            active = sdc_pkg::CNT_W'(MAX_OPERANDS);
        end else begin
            active = i_operand_count;
        end
        for (int j = 0; j < sdc_pkg::LANES; j++) begin
            lane_on[j] = sdc_pkg::CNT_W'(j) < active;
        end
    end

    assign lane_ok = &(r_s3.match | ~lane_on);

    // running product times extent as two half products; r_rs is within the cap after a join
    assign rs_plo  = sdc_pkg::PLO_W'(r_rs[sdc_pkg::HALF_W-1:0])
                   * sdc_pkg::PLO_W'(r_s3.item.ext);
    assign rs_phi  = PHI_W'(r_rs[sdc_pkg::RS_W-1:sdc_pkg::HALF_W]) * PHI_W'(r_s3.item.ext);
    assign rs_prod = PROD_W'(rs_plo) + {rs_phi, {sdc_pkg::HALF_W{1'b0}}};
    assign le_cap  = rs_prod <= PROD_W'(i_size_cap);

    assign contig    = le_cap && lane_ok;
    assign joins     = !r_first && contig;
    assign brk       = !r_first && !contig;
    assign gext_prod = r_gext * r_s3.item.ext;

    always_comb begin
        cnt   = '0;
        words = '0;
        // a break closes the open group and pushes the held one out
        h1v    = r_hv;
        h1ext  = r_hext;
        h1st   = r_hst;
        g1open = r_gopen;
        if (brk && r_gopen) begin
            if (r_hv) begin
                words[cnt] = mk(r_hext, r_hst, 1'b0, lane_on);
                cnt        = cnt + 1'b1;
            end
            h1v    = 1'b1;
            h1ext  = r_gext;
            h1st   = r_gst;
            g1open = 1'b0;
        end
        // extent-one dimensions never join or open a group
        g2open = g1open;
        g2ext  = r_gext;
        g2st   = r_gst;
        if (r_s3.item.ext != sdc_pkg::EXT_W'(1)) begin
            if (joins && g1open) begin
                g2ext = gext_prod;
            end else begin
                g2open = 1'b1;
                g2ext  = r_s3.item.ext;
            end
            g2st = r_s3.item.strides;
        end
        h2v   = h1v;
        h2ext = h1ext;
        h2st  = h1st;
        if (r_s3.item.fin) begin
            if (g2open) begin
                if (h1v) begin
                    words[cnt] = mk(h1ext, h1st, 1'b0, lane_on);
                    cnt        = cnt + 1'b1;
                end
                h2v   = 1'b1;
                h2ext = g2ext;
                h2st  = g2st;
            end
            // all extents one: a lone extent-one dimension with zero strides
            if (h2v) begin
                words[cnt] = mk(h2ext, h2st, 1'b1, lane_on);
            end else begin
                words[cnt] = mk(sdc_pkg::EXT_W'(1), '0, 1'b1, lane_on);
            end
            cnt = cnt + 1'b1;
        end
        if (joins) begin
            n_rs = rs_prod[sdc_pkg::RS_W-1:0];
        end else begin
            n_rs = sdc_pkg::RS_W'(r_s3.item.ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_gopen <= 1'b0;
            r_hv    <= 1'b0;
        end else if (i_go) begin
            if (r_s3.item.fin) begin
                r_first <= 1'b1;
                r_gopen <= 1'b0;
                r_hv    <= 1'b0;
            end else begin
                r_first <= 1'b0;
                r_gopen <= g2open;
                r_hv    <= h2v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rs   <= n_rs;
            r_gext <= g2ext;
            r_gst  <= g2st;
            r_hext <= h2ext;
            r_hst  <= h2st;
        end
    end

    assign o_emit.count = i_go ? cnt : '0;
    assign o_emit.words = words;

    `SDC_ASSERT_NXT(a_fin_rearms, i_clk, i_rst_n, i_go && r_s3.item.fin, r_first, "shape end did not rearm first dimension")
    `SDC_ASSERT_IMP(a_fin_emits, i_clk, i_rst_n, i_go && r_s3.item.fin, o_emit.count != '0, "shape end produced no word")
    `SDC_ASSERT_IMP(a_group_after_first, i_clk, i_rst_n, r_gopen, !r_first, "group open before any dimension")

endmodule

// ===== hw/rtl/sdc_out_fifo.sv =====
// Output word queue: takes up to three words per cycle, gives one per cycle on i_pop.
// Uses sdc_pkg and the assertion macros.
`include "stride_dimension_collapser_defines.svh"
module sdc_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sdc_pkg::t_emit i_emit,
    input  logic           i_pop,
    output logic           o_room,
    output logic           o_valid,
    output sdc_pkg::t_word o_word
);

    localparam logic [sdc_pkg::FIFO_CW-1:0] ROOM_MAX =
        sdc_pkg::FIFO_CW'(sdc_pkg::FIFO_DEPTH - sdc_pkg::MAX_EMIT);

    sdc_pkg::t_word                 r_mem [sdc_pkg::FIFO_DEPTH];
    logic [sdc_pkg::FIFO_AW-1:0]    r_wptr;
    logic [sdc_pkg::FIFO_AW-1:0]    r_rptr;
    logic [sdc_pkg::FIFO_CW-1:0]    r_count;
    logic                           pop;

    assign o_valid = r_count != '0;
    assign o_room  = r_count <= ROOM_MAX;
    assign o_word  = r_mem[r_rptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < sdc_pkg::MAX_EMIT; i++) begin
            if (sdc_pkg::EMIT_CNT_W'(i) < i_emit.count) begin
                r_mem[r_wptr + sdc_pkg::FIFO_AW'(i)] <= i_emit.words[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + sdc_pkg::FIFO_AW'(i_emit.count);
            r_rptr  <= r_rptr + sdc_pkg::FIFO_AW'(pop);
            r_count <= r_count + sdc_pkg::FIFO_CW'(i_emit.count) - sdc_pkg::FIFO_CW'(pop);
        end
    end

    `SDC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= sdc_pkg::FIFO_CW'(sdc_pkg::FIFO_DEPTH), "queue count beyond depth")
    `SDC_ASSERT_IMP(a_push_room, i_clk, i_rst_n, i_emit.count != '0, r_count <= ROOM_MAX, "words pushed without room")
    `SDC_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, i_emit.count == '0 && !pop, $stable(r_count), "queue count moved while idle")

endmodule

// ===== hw/rtl/stride_dimension_collapser.sv =====
// Stride dimension collapser, top level: config registers, pipeline control.
// Uses sdc_pkg, sdc_in_if, sdc_out_if, sdc_lane_front, sdc_collapse_core, sdc_out_fifo.
//
// Takes tensor dimensions outermost first, one word per dimension (extent, up to
// four operand strides, last-dimension flag) and emits the collapsed shape: adjacent
// dimensions merge while every active operand has stride * extent equal to the
// previous dimension's stride and the running element count stays within size_cap.
// Each merged word carries the product extent and the innermost member's strides;
// unused lanes read zero, and final_merged marks the last word of a shape. Since one
// finished group is held back to find the last one, words of a shape come out only
// as later dimensions arrive; everything left is flushed on the final dimension.
// A new dimension is taken every cycle unless the pipeline stalls. It passes through
// the two stride product stages, then the grouping stage, which writes zero to three
// words into an 8-word output queue; that stage waits until the queue has room for
// three. The output port drains one word per cycle while the receiver is ready, so
// the sustained rate is one dimension per cycle while shapes average at most one word
// per dimension, else the output port sets it. Configuration (index 0 size_cap, index
// 1 operand_count) must be written while the block is idle; nothing enforces this.
module stride_dimension_collapser #(
    parameter int MAX_OPERANDS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sdc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    sdc_in_if.sink                              i_in,
    sdc_out_if.source                           o_out
);

    logic [sdc_pkg::CAP_W-1:0] r_size_cap;
    logic [sdc_pkg::CNT_W-1:0] r_operand_count;

    // stage valid bits: stride multiply, stride compare, grouping
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;
    logic go;
    logic accept;
    logic room;

    sdc_pkg::t_item       in_item;
    sdc_pkg::t_match_item match_item;
    sdc_pkg::t_emit       emit;
    sdc_pkg::t_word       out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_cap      <= sdc_pkg::SIZE_CAP_RESET;
            r_operand_count <= sdc_pkg::OPERAND_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdc_pkg::CFG_SIZE_CAP: begin
                    r_size_cap <= i_cfg_data;
                end
                sdc_pkg::CFG_OPERAND_COUNT: begin
                    r_operand_count <= i_cfg_data[sdc_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Grouping fires only with room for its worst case; stalls ripple back from there.
    assign go     = r_v3 && room;
    assign en3    = !r_v3 || go;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = i_in.valid && en1;

    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign in_item.ext        = i_in.extent;
    assign in_item.strides[0] = i_in.stride_a;
    assign in_item.strides[1] = i_in.stride_b;
    assign in_item.strides[2] = i_in.stride_c;
    assign in_item.strides[3] = i_in.stride_d;
    assign in_item.fin        = i_in.final_dim;

    sdc_lane_front #(
        .MAX_OPERANDS (MAX_OPERANDS)
    ) u_front (
        .i_clk  (i_clk),
        .i_ld1  (accept),
        .i_ld2  (en2),
        .i_item (in_item),
        .o_item (match_item)
    );

    sdc_collapse_core #(
        .MAX_OPERANDS (MAX_OPERANDS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ld3           (en3),
        .i_go            (go),
        .i_item          (match_item),
        .i_size_cap      (r_size_cap),
        .i_operand_count (r_operand_count),
        .o_emit          (emit)
    );

    sdc_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_word  (out_word)
    );

    assign o_out.merged_extent   = out_word.ext;
    assign o_out.merged_stride_a = out_word.strides[0];
    assign o_out.merged_stride_b = out_word.strides[1];
    assign o_out.merged_stride_c = out_word.strides[2];
    assign o_out.merged_stride_d = out_word.strides[3];
    assign o_out.final_merged    = out_word.fin;

endmodule

// ===== dv/stride_dimension_collapser_tb.sv =====
// Self-checking testbench for stride_dimension_collapser: drives dimension words and
// checks every merged word against a cycle-free predictor of the collapse rules.
// Depends on sdc_pkg, sdc_in_if, sdc_out_if and the stride_dimension_collapser RTL.
module stride_dimension_collapser_tb;
    import sdc_pkg::*;

    localparam int MAX_OPERANDS = 4;
    localparam int CLK_HALF     = 6;     // 12-unit clock period
    localparam int SETTLE       = 16;    // covers two product stages, grouping stage, queue
    localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake on either side
    localparam int STALL_CYCLES = 80;    // long receiver hold-off, fills the output queue
    localparam int MAX_DIMS     = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sdc_in_if  in_if ();
    sdc_out_if out_if ();

    stride_dimension_collapser #(
        .MAX_OPERANDS(MAX_OPERANDS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_if),
        .o_out     (out_if)
    );

    // ------------------------------------------------------------------
    // Stimulus and expectation stores
    // ------------------------------------------------------------------
    t_item dim_backlog [$];      // dimension words not yet offered
    t_word merged_expect [$];    // merged words predicted, oldest first
    t_item dim_now;              // word currently on the input port

    int send_gap_pct;
    int recv_gap_pct;
    bit stall_request;
    bit stall_done;
    int stall_count;

    int fail_count;
    int dims_taken;
    int shapes_queued;
    int words_checked;
    int reg_writes;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Predictor state: a copy of the registers and of the collapse state
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] lanes_reg;

    t_strides         prev_stride;
    logic [63:0]      run_size;
    bit               grp_open;
    logic [EXT_W-1:0] grp_ext;
    t_strides         grp_stride;
    bit               held_ok;
    logic [EXT_W-1:0] held_ext;
    t_strides         held_stride;
    bit               first_dim;

    // Lane count register is clamped to 1..MAX_OPERANDS; 0 behaves as 1.
    function automatic int lanes_in_use();
        int n;
        n = lanes_reg;
        if (n < 1) n = 1;
        if (n > MAX_OPERANDS) n = MAX_OPERANDS;
        return n;
    endfunction

    task automatic clear_shape();
        prev_stride = '0;
        run_size    = '0;
        grp_open    = 1'b0;
        grp_ext     = '0;
        grp_stride  = '0;
        held_ok     = 1'b0;
        held_ext    = '0;
        held_stride = '0;
        first_dim   = 1'b1;
    endtask

    // Unused lanes always read zero on the output.
    task automatic emit_merged(input logic [EXT_W-1:0] ext, input t_strides st,
                               input logic fin);
        t_word w;
        int    n;
        n = lanes_in_use();
        w.ext = ext;
        for (int j = 0; j < LANES; j++)
            w.strides[j] = (j < n) ? st[j] : '0;
        w.fin = fin;
        merged_expect.push_back(w);
    endtask

    // A finished group goes to the holding slot; whatever sat there is released.
    task automatic close_group();
        if (!grp_open) return;
        if (held_ok) emit_merged(held_ext, held_stride, 1'b0);
        held_ok     = 1'b1;
        held_ext    = grp_ext;
        held_stride = grp_stride;
        grp_open    = 1'b0;
    endtask

    task automatic fold_dimension(input t_item d);
        logic [63:0] ext64;
        logic [63:0] cap64;
        logic [63:0] lim;
        bit          joins;
        bit          contig;
        int          n;
        n     = lanes_in_use();
        ext64 = {33'b0, d.ext};
        cap64 = {1'b0, cap_reg};
        joins = 1'b0;
        if (first_dim) begin
            run_size  = ext64;
            first_dim = 1'b0;
        end else begin
            lim    = cap64 + 64'd1;
            contig = 1'b1;
            // running element count saturates one above the cap
            if (ext64 != 0 && run_size > lim / ext64) begin
                run_size = lim;
            end else begin
                run_size = run_size * ext64;
                if (run_size > lim) run_size = lim;
            end
            if (run_size > cap64) contig = 1'b0;
            // contiguity: stride * extent, wrapped to 64 bits, equals outer stride
            for (int j = 0; j < n; j++)
                if (d.strides[j] * ext64 != prev_stride[j]) contig = 1'b0;
            if (!contig) begin
                close_group();
                run_size = ext64;
            end else begin
                joins = 1'b1;
            end
        end
        // extent-1 dims never open or extend a group
        if (d.ext != 1) begin
            if (joins && grp_open) begin
                grp_ext = grp_ext * d.ext;   // low 31 bits of the product
            end else begin
                grp_open = 1'b1;
                grp_ext  = d.ext;
            end
            grp_stride = d.strides;
        end
        prev_stride = d.strides;
        if (d.fin) begin
            close_group();
            if (held_ok) emit_merged(held_ext, held_stride, 1'b1);
            else         emit_merged(31'd1, '0, 1'b1);   // shape of all ones
            clear_shape();
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: offers backlog words, gaps at send_gap_pct. The predictor
    // runs on the word at the edge where it is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                fold_dimension(dim_now);
                dims_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (dim_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    dim_now            = dim_backlog.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.extent       <= dim_now.ext;
                    in_if.stride_a     <= dim_now.strides[0];
                    in_if.stride_b     <= dim_now.strides[1];
                    in_if.stride_c     <= dim_now.strides[2];
                    in_if.stride_d     <= dim_now.strides[3];
                    in_if.final_dim    <= dim_now.fin;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken merged word against the oldest
    // expectation, and drives ready (random gaps or the long hold-off).
    // ------------------------------------------------------------------
    task automatic check_merged();
        t_word want;
        if (merged_expect.size() == 0) begin
            $error("merged word with nothing expected: extent %0d final %0b",
                   out_if.merged_extent, out_if.final_merged);
            fail_count++;
            return;
        end
        want = merged_expect.pop_front();
        words_checked++;
        if (out_if.merged_extent !== want.ext) begin
            $error("merged_extent: expected %0d, got %0d", want.ext, out_if.merged_extent);
            fail_count++;
        end
        if (out_if.merged_stride_a !== want.strides[0]) begin
            $error("merged_stride_a: expected %h, got %h", want.strides[0],
                   out_if.merged_stride_a);
            fail_count++;
        end
        if (out_if.merged_stride_b !== want.strides[1]) begin
            $error("merged_stride_b: expected %h, got %h", want.strides[1],
                   out_if.merged_stride_b);
            fail_count++;
        end
        if (out_if.merged_stride_c !== want.strides[2]) begin
            $error("merged_stride_c: expected %h, got %h", want.strides[2],
                   out_if.merged_stride_c);
            fail_count++;
        end
        if (out_if.merged_stride_d !== want.strides[3]) begin
            $error("merged_stride_d: expected %h, got %h", want.strides[3],
                   out_if.merged_stride_d);
            fail_count++;
        end
        if (out_if.final_merged !== want.fin) begin
            $error("final_merged: expected %0b, got %0b", want.fin, out_if.final_merged);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) check_merged();
            if (stall_request && !stall_done) begin
                // hold off while the sender keeps offering; queue fills, input stalls
                out_if.ready <= 1'b0;
                stall_count++;
                if (stall_count >= STALL_CYCLES) stall_done = 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no handshake on either side for too long ends the run.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_dim(input logic [EXT_W-1:0] ext, input logic [63:0] sa,
                             input logic [63:0] sb, input logic [63:0] sc,
                             input logic [63:0] sd, input logic fin);
        t_item d;
        d.ext        = ext;
        d.strides[0] = sa;
        d.strides[1] = sb;
        d.strides[2] = sc;
        d.strides[3] = sd;
        d.fin        = fin;
        dim_backlog.push_back(d);
        if (fin) shapes_queued++;
    endtask

    // Register writes happen only with the block idle, so the predictor
    // copy can be updated right away.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_SIZE_CAP) cap_reg = data;
        else                     lanes_reg = data[CNT_W-1:0];
        reg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every word is taken and every merged word is back, then let
    // the pipeline empty of dims that produce nothing.
    task automatic drain_and_settle();
        while (dim_backlog.size() != 0 || in_if.valid || merged_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly ones and small sizes so groups form; sometimes any 31-bit value.
    function automatic logic [EXT_W-1:0] rand_extent();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 7)       return 31'd1;
        else if (pick < 11) return $urandom_range(2, 4);
        else if (pick < 15) return $urandom_range(0, 16);
        else if (pick < 16) return 31'd0;
        else if (pick < 18) return $urandom & 32'h7FFF_FFFF;
        else                return 31'd1 << $urandom_range(0, 30);
    endfunction

    function automatic logic [63:0] rand_stride();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)      return {$urandom, $urandom};
        else if (pick < 4) return -64'($urandom_range(1, 64));
        else               return 64'($urandom_range(0, 64));
    endfunction

    // Builds strides inner to outer so that outer = inner * inner extent,
    // unless a lane breaks (break_pct per lane and dim).
    task automatic queue_shape(input int ndims, input int break_pct);
        t_item dims [MAX_DIMS];
        for (int i = ndims - 1; i >= 0; i--) begin
            dims[i].ext = rand_extent();
            dims[i].fin = (i == ndims - 1);
            for (int j = 0; j < LANES; j++) begin
                if (i == ndims - 1 || $urandom_range(0, 99) < break_pct)
                    dims[i].strides[j] = rand_stride();
                else
                    dims[i].strides[j] = dims[i+1].strides[j] * dims[i+1].ext;
            end
        end
        for (int i = 0; i < ndims; i++) dim_backlog.push_back(dims[i]);
        shapes_queued++;
    endtask

    // Mostly well-formed contiguous shapes, some fully scrambled ones.
    task automatic queue_random(input int count);
        int n;
        int nd;
        n = 0;
        while (n < count) begin
            nd = $urandom_range(1, 6);
            queue_shape(nd, ($urandom_range(0, 9) < 8) ? 8 : 100);
            n += nd;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.extent     = '0;
        in_if.stride_a   = '0;
        in_if.stride_b   = '0;
        in_if.stride_c   = '0;
        in_if.stride_d   = '0;
        in_if.final_dim  = 1'b0;
        out_if.ready     = 1'b0;
        send_gap_pct     = 23;
        recv_gap_pct     = 71;
        stall_request    = 1'b0;
        stall_done       = 1'b0;
        stall_count      = 0;
        fail_count       = 0;
        dims_taken       = 0;
        shapes_queued    = 0;
        words_checked    = 0;
        reg_writes       = 0;
        quiet_cycles     = 0;
        cap_reg          = SIZE_CAP_RESET;
        lanes_reg        = OPERAND_COUNT_RESET;
        clear_shape();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset register values (one lane, cap 2^31-1) ---
        // all-ones shape: one word of extent 1, zero strides
        queue_dim(31'd1, 64'd9, 64'd8, 64'd7, 64'd6, 1'b0);
        queue_dim(31'd1, 64'd3, 64'd2, 64'd1, 64'd5, 1'b1);
        // single-dim shape; unused lanes must read zero
        queue_dim(31'd5, 64'd7, 64'd11, 64'd13, 64'd17, 1'b1);
        // fully contiguous 4x3x2 -> one word of 24
        queue_dim(31'd4, 64'd6, 64'd1, 64'd1, 64'd1, 1'b0);
        queue_dim(31'd3, 64'd2, 64'd1, 64'd1, 64'd1, 1'b0);
        queue_dim(31'd2, 64'd1, 64'd1, 64'd1, 64'd1, 1'b1);
        // break on every dim: last dim releases three words at once
        queue_dim(31'd2, 64'd100, 64'd0, 64'd0, 64'd0, 1'b0);
        queue_dim(31'd3, 64'd5, 64'd0, 64'd0, 64'd0, 1'b0);
        queue_dim(31'd2, 64'd1, 64'd0, 64'd0, 64'd0, 1'b1);
        // extreme extent and stride bit patterns, extent zero
        queue_dim(31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b0);
        queue_dim(31'd0, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        // shape left open across a lane count change
        queue_dim(31'd3, 64'd4, 64'd4, 64'd4, 64'd4, 1'b0);
        queue_dim(31'd2, 64'd2, 64'd2, 64'd2, 64'd2, 1'b0);
        drain_and_settle();
        write_reg(CFG_OPERAND_COUNT, 63'd4);
        // lane d breaks now that four lanes count
        queue_dim(31'd2, 64'd1, 64'd1, 64'd1, 64'd7, 1'b1);
        drain_and_settle();

        // cap of one: even contiguous dims cannot merge
        write_reg(CFG_SIZE_CAP, 63'd1);
        queue_dim(31'd2, 64'd2, 64'd2, 64'd2, 64'd2, 1'b0);
        queue_dim(31'd2, 64'd1, 64'd1, 64'd1, 64'd1, 1'b1);
        drain_and_settle();

        // largest cap, lane count 0 (acts as one): 2^51 group, extent wraps to 0
        write_reg(CFG_SIZE_CAP, 63'h7FFF_FFFF_FFFF_FFFF);
        write_reg(CFG_OPERAND_COUNT, 63'd0);
        queue_dim(31'd1 << 20, 64'd3 << 31, {$urandom, $urandom}, 64'd0, 64'd0, 1'b0);
        queue_dim(31'd1 << 20, 64'd3 << 11, {$urandom, $urandom}, 64'd0, 64'd0, 1'b0);
        queue_dim(31'd1 << 11, 64'd3, {$urandom, $urandom}, 64'd0, 64'd0, 1'b1);
        drain_and_settle();

        // lane count 7 (acts as four): negative strides, only lane d breaks
        write_reg(CFG_OPERAND_COUNT, 63'd7);
        queue_dim(31'd2, -64'sd4, 64'd8, 64'd12, 64'd5, 1'b0);
        queue_dim(31'd2, -64'sd2, 64'd4, 64'd6, 64'd3, 1'b1);
        drain_and_settle();

        // --- random, sender gaps 23%, receiver gaps 71% ---
        write_reg(CFG_SIZE_CAP, SIZE_CAP_RESET);
        write_reg(CFG_OPERAND_COUNT, 63'd2);
        queue_random(50);
        drain_and_settle();

        // --- random, gaps swapped, small cap so size breaks are common ---
        send_gap_pct = 71;
        recv_gap_pct = 23;
        write_reg(CFG_SIZE_CAP, 63'($urandom_range(2, 64)));
        write_reg(CFG_OPERAND_COUNT, 63'd3);
        queue_random(50);
        drain_and_settle();

        // --- random, no gaps, long receiver hold-off up front ---
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_reg(CFG_SIZE_CAP, 63'h7FFF_FFFF_FFFF_FFFF);
        write_reg(CFG_OPERAND_COUNT, 63'd4);
        stall_request = 1'b1;
        queue_random(50);
        drain_and_settle();

        if (merged_expect.size() != 0) begin
            $error("%0d merged words never arrived", merged_expect.size());
            fail_count++;
        end

        $display("Run took %0d dimension words in %0d shapes, checked %0d merged words",
                 dims_taken, shapes_queued, words_checked);
        $display("over %0d register writes (caps 1..max, lane counts 0..7), with a %0d-cycle hold-off",
                 reg_writes, STALL_CYCLES);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
